>>> sv/spct_pkg.sv
// shared shape codes and pair types for the shape pair collision test
package spct_pkg;

  typedef enum logic [1:0] {
    KIND_CIRCLE  = 2'd0,
    KIND_BOX     = 2'd1,
    KIND_SEGMENT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PAIR_NONE = 3'd0,
    PAIR_CC   = 3'd1,
    PAIR_CB   = 3'd2,
    PAIR_CS   = 3'd3,
    PAIR_BB   = 3'd4,
    PAIR_BS   = 3'd5,
    PAIR_SS   = 3'd6
  } pair_e;

endpackage

>>> sv/spct_core.sv
// pipelined exact geometry datapath: differences, products, sums, compares
module spct_core #(
  parameter int CoordBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  spct_pkg::pair_e        pair_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic        [CoordBits-2:0] r_i,
  input  logic        [CoordBits:0]   rsum_i,
  input  logic signed [CoordBits-1:0] p1x_i,
  input  logic signed [CoordBits-1:0] p1y_i,
  input  logic signed [CoordBits-1:0] p2x_i,
  input  logic signed [CoordBits-1:0] p2y_i,
  input  logic signed [CoordBits-1:0] q1x_i,
  input  logic signed [CoordBits-1:0] q1y_i,
  input  logic signed [CoordBits-1:0] q2x_i,
  input  logic signed [CoordBits-1:0] q2y_i,
  output logic                   valid_o,
  output logic                   hit_o
);
  import spct_pkg::*;

  localparam int DW = CoordBits + 2;  // differences, radius sum
  localparam int PW = 2 * DW;         // products
  localparam int SW = PW + 2;         // sums of products
  localparam int QW = 2 * SW;         // squared cross products
  localparam int TW = QW + 2;         // compare width
  localparam int HL = SW / 2;         // low half of a split sum
  localparam int HH = SW - HL;        // high half of a split sum

  typedef logic signed [DW-1:0] d_t;
  typedef logic signed [PW-1:0] p_t;
  typedef logic signed [SW-1:0] s_t;
  typedef logic signed [TW-1:0] t_t;

  // ---------------- stage 1: clamp point and differences ----------------
  logic  v1_q;
  pair_e pr1_q;
  d_t    rr1_q;           // radius (sum for circle pair)
  d_t    nx_q, ny_q;      // circle to nearest/first point
  d_t    ex_q, ey_q;      // circle to second endpoint
  d_t    lx_q, ly_q;      // segment vector p
  d_t    ccx_q, ccy_q;    // circle minus segment start
  logic  ib_q;            // endpoint inside box or box overlap
  // crossings: segment p (p1,p2) against segment q (q1,q2) and
  // second diagonal (p1.x,p2.y)-(p2.x,p1.y)
  d_t    sa_x_q, sa_y_q, sb_x_q, sb_y_q;
  d_t    a1x_q, a1y_q, a2x_q, a2y_q, b1x_q, b1y_q, b2x_q, b2y_q;
  d_t    g1x_q, g1y_q, g2x_q, g2y_q, h1x_q, h1y_q, h2x_q, h2y_q;
  d_t    k_x_q, k_y_q;

  logic signed [CoordBits-1:0] clx, cly;
  logic in1, in2, bb;

  function automatic d_t sx(input logic signed [CoordBits-1:0] v);
    sx = d_t'(v);
  endfunction

  always_comb begin
    if (cx_i < p1x_i) clx = p1x_i;
    else if (cx_i > p2x_i) clx = p2x_i;
    else clx = cx_i;
    if (cy_i < p1y_i) cly = p1y_i;
    else if (cy_i > p2y_i) cly = p2y_i;
    else cly = cy_i;
    in1 = (p1x_i <= q1x_i) && (q1x_i <= p2x_i) && (p1y_i <= q1y_i) && (q1y_i <= p2y_i);
    in2 = (p1x_i <= q2x_i) && (q2x_i <= p2x_i) && (p1y_i <= q2y_i) && (q2y_i <= p2y_i);
    bb  = (p1x_i <= q2x_i) && (p2x_i >= q1x_i) && (p1y_i <= q2y_i) && (p2y_i >= q1y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pr1_q <= pair_i;
    rr1_q <= (pair_i == PAIR_CC) ? d_t'({1'b0, rsum_i}) : d_t'({1'b0, r_i});
    ib_q  <= (pair_i == PAIR_BB) ? bb : (in1 || in2);
    if (pair_i == PAIR_CB) begin
      nx_q <= sx(clx) - sx(cx_i);
      ny_q <= sx(cly) - sx(cy_i);
    end else begin
      nx_q <= sx(p1x_i) - sx(cx_i);
      ny_q <= sx(p1y_i) - sx(cy_i);
    end
    ex_q  <= sx(p2x_i) - sx(cx_i);
    ey_q  <= sx(p2y_i) - sx(cy_i);
    lx_q  <= sx(p2x_i) - sx(p1x_i);
    ly_q  <= sx(p2y_i) - sx(p1y_i);
    ccx_q <= sx(cx_i) - sx(p1x_i);
    ccy_q <= sx(cy_i) - sx(p1y_i);
    // side(P,Q,A) = (P.x-Q.x)(A.y-P.y) + (P.y-Q.y)(P.x-A.x)
    // sides of p1,p2 w.r.t. line q
    sa_x_q <= sx(q1x_i) - sx(q2x_i);
    sa_y_q <= sx(q1y_i) - sx(q2y_i);
    a1x_q  <= sx(q1x_i) - sx(p1x_i);  a1y_q <= sx(p1y_i) - sx(q1y_i);
    a2x_q  <= sx(q1x_i) - sx(p2x_i);  a2y_q <= sx(p2y_i) - sx(q1y_i);
    // sides of q1,q2 w.r.t. line p
    sb_x_q <= sx(p1x_i) - sx(p2x_i);
    sb_y_q <= sx(p1y_i) - sx(p2y_i);
    b1x_q  <= sx(p1x_i) - sx(q1x_i);  b1y_q <= sx(q1y_i) - sx(p1y_i);
    b2x_q  <= sx(p1x_i) - sx(q2x_i);  b2y_q <= sx(q2y_i) - sx(p1y_i);
    // second diagonal d1=(p1x,p2y), d2=(p2x,p1y)
    g1x_q  <= sx(q1x_i) - sx(p1x_i);  g1y_q <= sx(p2y_i) - sx(q1y_i);
    g2x_q  <= sx(q1x_i) - sx(p2x_i);  g2y_q <= sx(p1y_i) - sx(q1y_i);
    k_x_q  <= sx(p1x_i) - sx(p2x_i);
    k_y_q  <= sx(p2y_i) - sx(p1y_i);
    h1x_q  <= sx(p1x_i) - sx(q1x_i);  h1y_q <= sx(q1y_i) - sx(p2y_i);
    h2x_q  <= sx(p1x_i) - sx(q2x_i);  h2y_q <= sx(q2y_i) - sx(p2y_i);
  end

  // ---------------- stage 2: products ----------------
  logic v2_q;
  pair_e pr2_q;
  logic ib2_q;
  p_t nn_x_q, nn_y_q, ee_x_q, ee_y_q, r2_q;
  p_t ll_x_q, ll_y_q, lc_x_q, lc_y_q, cr_a_q, cr_b_q;
  p_t s1a_q, s1b_q, s2a_q, s2b_q, s3a_q, s3b_q, s4a_q, s4b_q;
  p_t s5a_q, s5b_q, s6a_q, s6b_q, s7a_q, s7b_q, s8a_q, s8b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    pr2_q  <= pr1_q;
    ib2_q  <= ib_q;
    nn_x_q <= nx_q * nx_q;   nn_y_q <= ny_q * ny_q;
    ee_x_q <= ex_q * ex_q;   ee_y_q <= ey_q * ey_q;
    r2_q   <= rr1_q * rr1_q;
    ll_x_q <= lx_q * lx_q;   ll_y_q <= ly_q * ly_q;
    lc_x_q <= lx_q * ccx_q;  lc_y_q <= ly_q * ccy_q;
    cr_a_q <= lx_q * ccy_q;  cr_b_q <= ly_q * ccx_q;
    // line q: p1 and p2
    s1a_q <= sa_x_q * a1y_q; s1b_q <= sa_y_q * a1x_q;
    s2a_q <= sa_x_q * a2y_q; s2b_q <= sa_y_q * a2x_q;
    // line p: q1 and q2
    s3a_q <= sb_x_q * b1y_q; s3b_q <= sb_y_q * b1x_q;
    s4a_q <= sb_x_q * b2y_q; s4b_q <= sb_y_q * b2x_q;
    // line q: diagonal ends d1 and d2
    s5a_q <= sa_x_q * g1y_q; s5b_q <= sa_y_q * g1x_q;
    s6a_q <= sa_x_q * g2y_q; s6b_q <= sa_y_q * g2x_q;
    // diagonal line: q1 and q2
    s7a_q <= k_x_q * h1y_q;  s7b_q <= k_y_q * h1x_q;
    s8a_q <= k_x_q * h2y_q;  s8b_q <= k_y_q * h2x_q;
  end

  // ---------------- stage 3: sums and simple decisions ----------------
  logic v3_q;
  pair_e pr3_q;
  logic end_hit_q, ss_hit_q, bs_hit_q, seg_ok_q;
  s_t cr_q, len2_q;
  p_t r2_3_q;

  function automatic logic [1:0] sgn(input s_t v);
    sgn = {v < 0, v > 0};
  endfunction

  function automatic logic opp(input logic [1:0] a, input logic [1:0] b);
    opp = (a[1] && b[0]) || (a[0] && b[1]);
  endfunction

  s_t n2, e2, rsq, len2, along;
  logic [1:0] z1, z2, z3, z4, z5, z6, z7, z8;

  always_comb begin
    n2    = s_t'(nn_x_q) + s_t'(nn_y_q);
    e2    = s_t'(ee_x_q) + s_t'(ee_y_q);
    rsq   = s_t'(r2_q);
    len2  = s_t'(ll_x_q) + s_t'(ll_y_q);
    along = s_t'(lc_x_q) + s_t'(lc_y_q);
    z1 = sgn(s_t'(s1a_q) + s_t'(s1b_q));
    z2 = sgn(s_t'(s2a_q) + s_t'(s2b_q));
    z3 = sgn(s_t'(s3a_q) + s_t'(s3b_q));
    z4 = sgn(s_t'(s4a_q) + s_t'(s4b_q));
    z5 = sgn(s_t'(s5a_q) + s_t'(s5b_q));
    z6 = sgn(s_t'(s6a_q) + s_t'(s6b_q));
    z7 = sgn(s_t'(s7a_q) + s_t'(s7b_q));
    z8 = sgn(s_t'(s8a_q) + s_t'(s8b_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    pr3_q     <= pr2_q;
    r2_3_q    <= r2_q;
    end_hit_q <= (n2 <= rsq) || ((pr2_q == PAIR_CS) && (e2 <= rsq));
    seg_ok_q  <= (len2 > 0) && (along >= 0) && (along <= len2);
    cr_q      <= s_t'(cr_a_q) - s_t'(cr_b_q);
    len2_q    <= len2;
    ss_hit_q  <= opp(z1, z2) && opp(z3, z4);
    // box pair is the interval overlap alone
    bs_hit_q  <= (pr2_q == PAIR_BB) ? ib2_q :
                 (ib2_q || (opp(z1, z2) && opp(z3, z4)) || (opp(z5, z6) && opp(z7, z8)));
  end

  // ---------------- stage 4: partial products of squared cross and r^2 * len2 ----------------
  logic v4_q;
  pair_e pr4_q;
  logic end_hit4_q, ss4_q, bs4_q, seg_ok4_q;
  logic signed [2*HH-1:0]   hh_q;
  logic signed [HH+HL:0]    hl_q;
  logic        [2*HL-1:0]   ll_q;
  logic signed [PW+HL:0]    rlo_q;
  logic signed [PW+HH-1:0]  rhi_q;

  logic        [HL-1:0] crl, lnl;
  logic signed [HH-1:0] crh, lnh;

  // split the cross product and the length into halves
  assign crl = cr_q[HL-1:0];
  assign crh = cr_q[SW-1:HL];
  assign lnl = len2_q[HL-1:0];
  assign lnh = len2_q[SW-1:HL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    pr4_q      <= pr3_q;
    end_hit4_q <= end_hit_q;
    ss4_q      <= ss_hit_q;
    bs4_q      <= bs_hit_q;
    seg_ok4_q  <= seg_ok_q;
    hh_q       <= crh * crh;
    hl_q       <= crh * $signed({1'b0, crl});
    ll_q       <= crl * crl;
    rlo_q      <= r2_3_q * $signed({1'b0, lnl});
    rhi_q      <= r2_3_q * lnh;
  end

  // ---------------- stage 5: recombine partial products ----------------
  logic v5_q;
  pair_e pr5_q;
  logic end_hit5_q, ss5_q, bs5_q, seg_ok5_q;
  t_t crsq5_q, rl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    pr5_q      <= pr4_q;
    end_hit5_q <= end_hit4_q;
    ss5_q      <= ss4_q;
    bs5_q      <= bs4_q;
    seg_ok5_q  <= seg_ok4_q;
    crsq5_q    <= (t_t'(hh_q) <<< (2 * HL)) + (t_t'(hl_q) <<< (HL + 1)) + t_t'(ll_q);
    rl_q       <= (t_t'(rhi_q) <<< HL) + t_t'(rlo_q);
  end

  // ---------------- stage 6: final select ----------------
  logic v6_q, hit_q, hit_d;

  always_comb begin
    case (pr5_q)
      PAIR_CC, PAIR_CB: hit_d = end_hit5_q;
      PAIR_CS: hit_d = end_hit5_q || (seg_ok5_q && (crsq5_q <= rl_q));
      PAIR_BB: hit_d = bs5_q;
      PAIR_BS: hit_d = bs5_q;
      PAIR_SS: hit_d = ss5_q;
      default: hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v6_q  <= v5_q;
      hit_q <= hit_d;
    end
  end

  assign valid_o = v6_q;
  assign hit_o   = hit_q;

endmodule

>>> sv/shape_pair_collision_test_unit.sv
// top level of the shape pair collision test
// Accepts one shape pair per cycle (busy is always low) and returns its hit
// flag with done_o at the end of a six stage pipeline of operand
// routing with differences, products, sums, split partial products of the
// squared cross product and of the radius-weighted length, their
// recombination and the final pick. The receiver cannot stall; every pair
// gives exactly one result, in order. Reset clears the stage valid bits and the hit flag.
module shape_pair_collision_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   a_kind_i,
  input  logic signed [COORD_BITS-1:0] a_x1_i,
  input  logic signed [COORD_BITS-1:0] a_y1_i,
  input  logic signed [COORD_BITS-1:0] a_x2_i,
  input  logic signed [COORD_BITS-1:0] a_y2_i,
  input  logic [COORD_BITS-2:0]        a_radius_i,
  input  logic [1:0]                   b_kind_i,
  input  logic signed [COORD_BITS-1:0] b_x1_i,
  input  logic signed [COORD_BITS-1:0] b_y1_i,
  input  logic signed [COORD_BITS-1:0] b_x2_i,
  input  logic signed [COORD_BITS-1:0] b_y2_i,
  input  logic [COORD_BITS-2:0]        b_radius_i,
  output logic                         done_o,
  output logic                         hit_o
);
  import spct_pkg::*;

  pair_e pair;
  logic  swap;
  logic [COORD_BITS:0] rsum;
  logic [COORD_BITS-2:0] r_sel;
  logic signed [COORD_BITS-1:0] cx, cy, p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
  kind_e ka, kb;

  assign busy = 1'b0;
  assign ka = kind_e'(a_kind_i);
  assign kb = kind_e'(b_kind_i);

  // classify the pair; swap puts circle or box first
  always_comb begin
    pair = PAIR_NONE;
    swap = 1'b0;
    case ({ka, kb})
      {KIND_CIRCLE, KIND_CIRCLE}:   pair = PAIR_CC;
      {KIND_CIRCLE, KIND_BOX}:      pair = PAIR_CB;
      {KIND_CIRCLE, KIND_SEGMENT}:  pair = PAIR_CS;
      {KIND_BOX, KIND_CIRCLE}:      begin pair = PAIR_CB; swap = 1'b1; end
      {KIND_BOX, KIND_BOX}:         pair = PAIR_BB;
      {KIND_BOX, KIND_SEGMENT}:     pair = PAIR_BS;
      {KIND_SEGMENT, KIND_CIRCLE}:  begin pair = PAIR_CS; swap = 1'b1; end
      {KIND_SEGMENT, KIND_BOX}:     begin pair = PAIR_BS; swap = 1'b1; end
      {KIND_SEGMENT, KIND_SEGMENT}: pair = PAIR_SS;
      default:                      pair = PAIR_NONE;
    endcase
  end

  // operand routing: circle is c, box or first segment is p, other is q
  always_comb begin
    rsum = {2'b00, a_radius_i} + {2'b00, b_radius_i};
    if (swap) begin
      cx = b_x1_i; cy = b_y1_i; r_sel = b_radius_i;
      p1x = b_x1_i; p1y = b_y1_i; p2x = b_x2_i; p2y = b_y2_i;
      q1x = a_x1_i; q1y = a_y1_i; q2x = a_x2_i; q2y = a_y2_i;
    end else begin
      cx = a_x1_i; cy = a_y1_i; r_sel = a_radius_i;
      p1x = a_x1_i; p1y = a_y1_i; p2x = a_x2_i; p2y = a_y2_i;
      q1x = b_x1_i; q1y = b_y1_i; q2x = b_x2_i; q2y = b_y2_i;
    end
    // circle pairs use box or segment as p
    if (pair == PAIR_CB || pair == PAIR_CS) begin
      if (swap) begin
        cx = b_x1_i; cy = b_y1_i; r_sel = b_radius_i;
        p1x = a_x1_i; p1y = a_y1_i; p2x = a_x2_i; p2y = a_y2_i;
      end else begin
        p1x = b_x1_i; p1y = b_y1_i; p2x = b_x2_i; p2y = b_y2_i;
      end
    end
    if (pair == PAIR_CC) begin
      p1x = b_x1_i; p1y = b_y1_i;
    end
  end

  logic core_v;

  spct_core #(
    .CoordBits(COORD_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .pair_i  (pair),
    .cx_i    (cx),
    .cy_i    (cy),
    .r_i     (r_sel),
    .rsum_i  (rsum),
    .p1x_i   (p1x),
    .p1y_i   (p1y),
    .p2x_i   (p2x),
    .p2y_i   (p2y),
    .q1x_i   (q1x),
    .q1y_i   (q1y),
    .q2x_i   (q2x),
    .q2y_i   (q2y),
    .valid_o (core_v),
    .hit_o   (hit_o)
  );

  assign done_o = core_v;

endmodule
